>>> rtl/rcla_pkg.sv
// Package for the radio command line assembler.
// Holds result kinds, queue command types and character classification.
// No dependencies.
`default_nettype none

package rcla_pkg;

  typedef enum logic [1:0] {
    KIND_COMMAND  = 2'd0,
    KIND_LINE     = 2'd1,
    KIND_OVERFLOW = 2'd2
  } kind_t;

  typedef enum logic {
    OP_EMIT  = 1'b0,
    OP_FLUSH = 1'b1
  } op_t;

  // Work handed from the front to the back; line length travels beside it.
  typedef struct packed {
    op_t        op;
    kind_t      kind;
    logic [7:0] ch;
  } cmd_t;

  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_S = 8'h73;
  localparam logic [7:0] CH_LOWER_H = 8'h68;
  localparam logic [7:0] CH_LOWER_V = 8'h76;
  localparam logic [7:0] CH_LOWER_P = 8'h70;
  localparam logic [7:0] CH_QUERY   = 8'h3F;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_BIT   = 8'h20;

  function automatic logic is_single_command(input logic [7:0] c);
    logic [7:0] f;
    f = c;
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      f = c | CASE_BIT;
    end
    return (f == CH_LOWER_A) || (f == CH_LOWER_S) || (f == CH_LOWER_H) ||
           (f == CH_LOWER_V) || (f == CH_LOWER_P) || (f == CH_QUERY);
  endfunction

  function automatic logic is_line_end(input logic [7:0] c);
    return (c == CH_CR) || (c == CH_LF);
  endfunction

endpackage

`default_nettype wire

>>> rtl/rcla_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module rcla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 63,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/rcla_fifo.sv
// Small register queue between front and back.
// No dependencies.
`default_nettype none

module rcla_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2,
  localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire logic [W-1:0] wdata,
  output logic              full,
  input  wire logic         pop,
  output logic      [W-1:0] rdata,
  output logic              empty
);

  logic [W-1:0]  slots [DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] count;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign rdata = slots[rptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push && !full) begin
        wptr <= ptr_inc(wptr);
      end
      if (pop && !empty) begin
        rptr <= ptr_inc(rptr);
      end
      unique case ({push && !full, pop && !empty})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/rcla_front.sv
// Front end: accepts characters, classifies them, fills the line store
// and queues work for the back end. Depends on rcla_pkg.
`default_nettype none

module rcla_front
  import rcla_pkg::*;
#(
  parameter int BUFFER_BYTES = 64,
  localparam int LINE_CAP    = BUFFER_BYTES - 1,
  localparam int CNT_W       = $clog2(BUFFER_BYTES),
  localparam int AW          = (LINE_CAP > 1) ? $clog2(LINE_CAP) : 1
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [7:0]       char_in,
  output logic                  q_push,
  output cmd_t                  q_cmd,
  output logic      [CNT_W-1:0] q_len,
  input  wire logic             q_full,
  input  wire logic             line_done,
  output logic                  ram_we,
  output logic      [AW-1:0]    ram_waddr,
  output logic      [7:0]       ram_wdata
);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             flush_pend;
  logic             take;

  // Hold input while the queue is full or the line store is being replayed.
  assign in_stall = q_full || flush_pend;
  assign take     = in_valid && !in_stall;

  assign ram_waddr = count[AW-1:0];
  assign ram_wdata = char_in;
  assign q_len     = count;

  always_comb begin
    q_push     = 1'b0;
    q_cmd      = '{op: OP_EMIT, kind: KIND_COMMAND, ch: char_in};
    ram_we     = 1'b0;
    count_next = count;
    if (take) begin
      priority if (is_single_command(char_in)) begin
        q_push     = 1'b1;
        count_next = '0;
      end else if (is_line_end(char_in)) begin
        q_push     = (count != '0);
        q_cmd      = '{op: OP_FLUSH, kind: KIND_LINE, ch: 8'h00};
        count_next = '0;
      end else if (count < CNT_W'(LINE_CAP)) begin
        ram_we     = 1'b1;
        count_next = count + CNT_W'(1);
      end else begin
        q_push     = 1'b1;
        q_cmd      = '{op: OP_EMIT, kind: KIND_OVERFLOW, ch: 8'h00};
        count_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      flush_pend <= 1'b0;
    end else begin
      count <= count_next;
      if (q_push && (q_cmd.op == OP_FLUSH)) begin
        flush_pend <= 1'b1;
      end else if (line_done) begin
        flush_pend <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/rcla_back.sv
// Back end: pops queued work, emits single results or replays a line
// from the line store into the output register. Depends on rcla_pkg.
`default_nettype none

module rcla_back
  import rcla_pkg::*;
#(
  parameter int BUFFER_BYTES = 64,
  localparam int LINE_CAP    = BUFFER_BYTES - 1,
  localparam int CNT_W       = $clog2(BUFFER_BYTES),
  localparam int AW          = (LINE_CAP > 1) ? $clog2(LINE_CAP) : 1
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             q_empty,
  input  wire cmd_t             q_cmd,
  input  wire logic [CNT_W-1:0] q_len,
  output logic                  q_pop,
  output logic                  line_done,
  output logic      [AW-1:0]    ram_raddr,
  input  wire logic [7:0]       ram_rdata,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic      [1:0]       result_kind,
  output logic      [7:0]       char_out,
  output logic                  last
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_DATA = 3'b100
  } state_t;

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] idx_next;
  logic [CNT_W-1:0] len;
  logic             out_free;
  logic             load;
  logic [1:0]       load_kind;
  logic [7:0]       load_ch;
  logic             load_last;
  logic             is_last_char;

  assign out_free     = !out_valid || !out_stall;
  assign ram_raddr    = idx[AW-1:0];
  assign is_last_char = ((idx + CNT_W'(1)) == len);

  always_comb begin
    state_next = state;
    idx_next   = idx;
    q_pop      = 1'b0;
    line_done  = 1'b0;
    load       = 1'b0;
    load_kind  = q_cmd.kind;
    load_ch    = q_cmd.ch;
    load_last  = 1'b1;
    unique case (state)
      ST_IDLE: begin
        if (!q_empty && out_free) begin
          q_pop = 1'b1;
          if (q_cmd.op == OP_FLUSH) begin
            idx_next   = '0;
            state_next = ST_READ;
          end else begin
            load = 1'b1;
          end
        end
      end
      ST_READ: begin
        state_next = ST_DATA;
      end
      ST_DATA: begin
        if (out_free) begin
          load      = 1'b1;
          load_kind = KIND_LINE;
          load_ch   = ram_rdata;
          load_last = is_last_char;
          if (is_last_char) begin
            line_done  = 1'b1;
            state_next = ST_IDLE;
          end else begin
            idx_next   = idx + CNT_W'(1);
            state_next = ST_READ;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    if (q_pop && (q_cmd.op == OP_FLUSH)) begin
      len <= q_len;
    end
    if (load) begin
      result_kind <= load_kind;
      char_out    <= load_ch;
      last        <= load_last;
    end
  end

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (state == ST_IDLE))
    else $error("queue popped while replaying a line");

  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> (len != '0) && (idx < len))
    else $error("replay index out of line range");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    line_done |=> out_valid && last && (result_kind == KIND_LINE))
    else $error("line end without marked last character");

  a_read_then_data: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |=> (state == ST_DATA))
    else $error("read cycle not followed by data cycle");

endmodule

`default_nettype wire

>>> rtl/radio_command_line_assembler.sv
// Radio command line assembler, top level.
// Uses rcla_pkg, rcla_front, rcla_fifo, rcla_back and rcla_ram.
//
// Input channel: one received byte char_in per transfer (in_valid/in_stall).
// Output channel: result_kind, char_out, last per transfer
// (out_valid/out_stall).
//
// The letters a s h v p ? (either case) produce one command result at once.
// CR or LF replays the held line, one line character per transfer, the last
// one marked; an empty line gives nothing. Other bytes are stored up to
// BUFFER_BYTES-1; one more gives a single overflow result and clears the line.
// Flow: the front classifies each byte and queues work in a two-entry queue.
// A single result goes from the queue into the registered output.
// Each character of a line is read from the line store RAM by a registered
// read (ST_READ), then loaded into the output register (ST_DATA); input
// stays stalled until the last character is loaded. Other bytes are only
// written to the line store. Output stall holds the output register and
// backs up into the queue, then into in_stall. Reset clears the line count,
// queue and output valid; the line store needs no clearing, only written
// entries are read.
`default_nettype none

module radio_command_line_assembler
  import rcla_pkg::*;
#(
  parameter int BUFFER_BYTES = 64
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] char_in,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic      [1:0] result_kind,
  output logic      [7:0] char_out,
  output logic            last
);

  localparam int LINE_CAP = BUFFER_BYTES - 1;
  localparam int CNT_W    = $clog2(BUFFER_BYTES);
  localparam int AW       = (LINE_CAP > 1) ? $clog2(LINE_CAP) : 1;
  localparam int QW       = $bits(cmd_t) + CNT_W;
  localparam int Q_DEPTH  = 2;

  // front -> queue
  logic             f_push;
  cmd_t             f_cmd;
  logic [CNT_W-1:0] f_len;
  logic             q_full;

  // queue -> back
  logic [QW-1:0]    q_rdata;
  logic             q_empty;
  logic             q_pop;
  cmd_t             b_cmd;
  logic [CNT_W-1:0] b_len;

  // line store ports
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [7:0]       ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [7:0]       ram_rdata;

  // back tells front the line store is free again
  logic             line_done;

  assign b_cmd = q_rdata[QW-1:CNT_W];
  assign b_len = q_rdata[CNT_W-1:0];

  rcla_front #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .char_in   (char_in),
    .q_push    (f_push),
    .q_cmd     (f_cmd),
    .q_len     (f_len),
    .q_full    (q_full),
    .line_done (line_done),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata)
  );

  rcla_fifo #(
    .W    (QW),
    .DEPTH(Q_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (f_push),
    .wdata ({f_cmd, f_len}),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  // Line store: written by the front, replayed by the back.
  rcla_ram #(
    .WIDTH(8),
    .DEPTH(LINE_CAP)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rcla_back #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_cmd       (b_cmd),
    .q_len       (b_len),
    .q_pop       (q_pop),
    .line_done   (line_done),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .result_kind (result_kind),
    .char_out    (char_out),
    .last        (last)
  );

endmodule

`default_nettype wire
